FILE: src/salru_pkg.sv
// shared types and constants of the set-associative tag store with lru replacement
// no dependencies; imported by salru_ctrl, salru_dp and set_assoc_cache_tags_lru
package salru_pkg;

    // default sizing
    localparam int DEF_MAX_WAYS  = 16;
    localparam int DEF_MAX_SETS  = 1024;
    localparam int DEF_ADDR_BITS = 13;

    // field widths fixed by the interface
    localparam int ADDR_W      = 13;
    localparam int SET_OUT_W   = 10;
    localparam int WAY_OUT_W   = 4;
    localparam int TAG_MAX_W   = 13;
    localparam int RANK_W      = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

    // configuration register indexes and limits
    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] CFG_SET_COUNT  = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;
    localparam logic [2:0] BSL_MAX        = 3'd6;

    // access mode
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_STORE = 1'b1;

    // result kind
    typedef enum logic [1:0] {
        EV_LOAD_MISS = 2'd0,
        EV_LOAD_HIT  = 2'd1,
        EV_STORE     = 2'd2
    } event_t;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;   // write one cleared row, advance clear pointer
        logic load_in;  // capture input beat, split address
        logic rd;       // read the addressed row
        logic eval;     // tag compare, free-way search
        logic scan;     // one step of the least-recent search
        logic commit;   // write row back, load result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

FILE: src/salru_ctrl.sv
// sequencing state machine of the tag store: clearing pass, lookup, victim search, write-back
// depends on salru_pkg; drives salru_dp through cmd_t and watches sts_t
module salru_ctrl import salru_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = sts.need_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/salru_dp.sv
// datapath of the tag store: address split, row memory, tag compare, victim search,
// rank update and result register; depends on salru_pkg, commanded by salru_ctrl
module salru_dp import salru_pkg::*; #(
    parameter int MAX_WAYS  = DEF_MAX_WAYS,
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  cmd_t                                    cmd,
    output sts_t                                    sts,
    input  logic                                    in_mode,
    input  logic [ADDR_W-1:0]                       in_address,
    input  logic [2:0]                              bsl_eff,
    input  logic [3:0]                              scl_eff,
    input  logic [$clog2(MAX_WAYS+1)-1:0]           n_ways,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output event_t                                  out_event,
    output logic [SET_OUT_W-1:0]                    out_set,
    output logic [WAY_OUT_W-1:0]                    out_way
);

    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int CNT_W = $clog2(MAX_WAYS + 1);
    localparam int TAG_W = (ADDR_BITS < TAG_MAX_W) ? ADDR_BITS : TAG_MAX_W;
    localparam logic [SET_W-1:0] SET_LAST = SET_W'(MAX_SETS - 1);

    typedef struct packed {
        logic [MAX_WAYS-1:0]                         valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0]             rank;
        logic [MAX_WAYS-1:0][TAG_W-1:0]              tag;
    } row_t;

    row_t row_mem [MAX_SETS];
    row_t rd_row_reg;
    row_t new_row;
    row_t mem_wdata;

    logic [SET_W-1:0] clr_cnt_reg;
    logic [SET_W-1:0] mem_waddr;
    logic             mem_we;

    logic             mode_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             hit_reg;
    logic [WAY_W-1:0] way_reg;
    logic [CNT_W-1:0] idx_reg;

    logic                 out_valid_reg;
    event_t               out_event_reg;
    logic [SET_OUT_W-1:0] out_set_reg;
    logic [WAY_OUT_W-1:0] out_way_reg;

    logic [ADDR_BITS-1:0] addr_w;
    logic [ADDR_BITS-1:0] block_id;
    logic [ADDR_BITS-1:0] set_mask;

    logic [MAX_WAYS-1:0] match_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic [WAY_W-1:0]    match_way;
    logic [WAY_W-1:0]    inv_way;
    logic                hit_c;

    logic              was_valid;
    logic [RANK_W-1:0] cur_rank;

    // address split
    assign addr_w   = ADDR_BITS'(in_address);
    assign block_id = addr_w >> bsl_eff;
    assign set_mask = ~({ADDR_BITS{1'b1}} << scl_eff);

    // tag compare and lowest free way among the ways in use
    always_comb begin
        match_vec = '0;
        inv_vec   = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (CNT_W'(i) < n_ways) begin
                match_vec[i] = rd_row_reg.valid[i] && (rd_row_reg.tag[i] == tag_reg);
                inv_vec[i]   = !rd_row_reg.valid[i];
            end
        end
        match_way = '0;
        inv_way   = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                match_way = WAY_W'(i);
            end
            if (inv_vec[i]) begin
                inv_way = WAY_W'(i);
            end
        end
    end

    assign hit_c = (mode_reg == MODE_LOAD) && (|match_vec);

    // lru update: newer ways (all if the touched one was free) age by one, saturating
    always_comb begin
        new_row   = rd_row_reg;
        was_valid = rd_row_reg.valid[way_reg];
        cur_rank  = rd_row_reg.rank[way_reg];
        for (int i = 0; i < MAX_WAYS; i++) begin
            if ((CNT_W'(i) < n_ways) && (WAY_W'(i) != way_reg) && rd_row_reg.valid[i]
                && (!was_valid || (rd_row_reg.rank[i] < cur_rank))
                && (rd_row_reg.rank[i] != RANK_MAX)) begin
                new_row.rank[i] = rd_row_reg.rank[i] + 4'd1;
            end
        end
        new_row.rank[way_reg]  = '0;
        new_row.valid[way_reg] = 1'b1;
        if (!hit_reg) begin
            new_row.tag[way_reg] = tag_reg;
        end
    end

    assign mem_we    = cmd.clr_wr | cmd.commit;
    assign mem_waddr = cmd.clr_wr ? clr_cnt_reg : set_reg;
    assign mem_wdata = cmd.clr_wr ? '0 : new_row;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd) begin
            rd_row_reg <= row_mem[set_reg];
        end
    end

    // clear pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_wr && (clr_cnt_reg != SET_LAST)) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // item payload and search registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg <= in_mode;
            set_reg  <= SET_W'(block_id & set_mask);
            tag_reg  <= TAG_W'(block_id >> scl_eff);
        end
        if (cmd.eval) begin
            hit_reg <= hit_c;
            idx_reg <= CNT_W'(1);
            if (hit_c) begin
                way_reg <= match_way;
            end else if (|inv_vec) begin
                way_reg <= inv_way;
            end else begin
                way_reg <= '0;
            end
        end
        if (cmd.scan) begin
            idx_reg <= idx_reg + 1'b1;
            if (rd_row_reg.rank[idx_reg[WAY_W-1:0]] > rd_row_reg.rank[way_reg]) begin
                way_reg <= idx_reg[WAY_W-1:0];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (mode_reg == MODE_STORE) begin
                out_event_reg <= EV_STORE;
            end else if (hit_reg) begin
                out_event_reg <= EV_LOAD_HIT;
            end else begin
                out_event_reg <= EV_LOAD_MISS;
            end
            out_set_reg <= SET_OUT_W'(set_reg);
            out_way_reg <= WAY_OUT_W'(way_reg);
        end
    end

    assign sts.clr_last  = (clr_cnt_reg == SET_LAST);
    assign sts.need_scan = !hit_c && !(|inv_vec);
    assign sts.scan_done = (idx_reg >= n_ways);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;
    assign out_set   = out_set_reg;
    assign out_way   = out_way_reg;

endmodule

FILE: src/set_assoc_cache_tags_lru.sv
// top level of the set-associative tag store with lru replacement
// depends on salru_pkg, salru_ctrl and salru_dp
//
// Each input beat carries a word address and a mode (load or store). The address is split
// into block offset, set and tag using the configured block size and set count. A load
// compares the tag against every way in use of its set; a hit makes that way most recent,
// a miss fills the victim way. A store always fills the victim way without a hit check.
// The victim is the lowest-index invalid way, else the least recent way (lowest index on
// ties). One result beat is produced per input beat: the kind (load miss, load hit, store),
// the set index and the way that hit or was filled. Timing: after reset the block walks
// once through the row memory to clear valid bits and ranks, one row per cycle, and
// accepts no input beat until that pass is done (configuration writes are taken
// throughout). An item then passes through the read, evaluate and write-back states before
// ready comes back for the next beat. A load hit or a free way goes straight to
// write-back; otherwise the least recent of the ways in use is searched first, walking
// the ranks of the row one way per cycle. The set's row sits in a single-port memory that
// is read once and written once per item. A finished result waits in an output register,
// so the next beat is accepted while it is pending; write-back stalls only when a second
// result would overtake an untaken one. Configuration: a value of 7 for the block size
// is taken as 6, a set count beyond MAX_SETS is lowered to fit, a way count of zero is
// taken as one and one above MAX_WAYS as MAX_WAYS. Stored contents are kept across
// configuration writes, which the user must make only while the block is idle; the block
// does not enforce this. cfg_ready is always high; indexes beyond the list are ignored.
module set_assoc_cache_tags_lru import salru_pkg::*; #(
    parameter int MAX_WAYS  = DEF_MAX_WAYS,
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [12:0] address, [15:13] zero
    input  logic        s_tuser,    // [0] mode
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [9:0] set_index, [13:10] way_used, [15:14] zero
    output logic [1:0]  m_tuser,    // [1:0] event_res
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int CNT_W   = $clog2(MAX_WAYS + 1);
    // largest set count log2 that still fits the row memory
    localparam int SCL_MAX = $clog2(MAX_SETS + 1) - 1;

    logic [2:0] bsl_reg;
    logic [3:0] scl_reg;
    logic [4:0] ways_reg;

    logic [2:0]       bsl_eff;
    logic [3:0]       scl_eff;
    logic [CNT_W-1:0] n_ways;

    cmd_t   cmd;
    sts_t   sts;
    event_t out_event;
    logic [SET_OUT_W-1:0] out_set;
    logic [WAY_OUT_W-1:0] out_way;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsl_reg  <= 3'd0;
            scl_reg  <= 4'd0;
            ways_reg <= 5'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BLOCK_SIZE: bsl_reg  <= cfg_data[2:0];
                CFG_SET_COUNT:  scl_reg  <= cfg_data[3:0];
                CFG_WAYS:       ways_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp the raw settings into the range the storage supports
    assign bsl_eff = (bsl_reg > BSL_MAX) ? BSL_MAX : bsl_reg;
    assign scl_eff = (scl_reg > 4'(SCL_MAX)) ? 4'(SCL_MAX) : scl_reg;

    always_comb begin
        if (ways_reg == 5'd0) begin
            n_ways = CNT_W'(1);
        end else if (32'(ways_reg) > 32'(MAX_WAYS)) begin
            n_ways = CNT_W'(MAX_WAYS);
        end else begin
            n_ways = CNT_W'(ways_reg);
        end
    end

    salru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    salru_dp #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_mode    (s_tuser),
        .in_address (s_tdata[ADDR_W-1:0]),
        .bsl_eff    (bsl_eff),
        .scl_eff    (scl_eff),
        .n_ways     (n_ways),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_event  (out_event),
        .out_set    (out_set),
        .out_way    (out_way)
    );

    // result beat packing
    assign m_tdata = {2'b00, out_way, out_set};
    assign m_tuser = out_event;

endmodule
